### design/crsr_pkg.sv
// Shared types, widths and codes of the Catmull-Rom stereo resampler.
// Used by all modules but the port checker; depends on nothing else.
package crsr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 24;
    localparam int RATIO_W     = 29;
    localparam int POS_W       = 29;

    // Coefficient and partial-result widths of one cubic evaluation.
    localparam int A_W       = SAMPLE_BITS + 3;
    localparam int B_W       = SAMPLE_BITS + 4;
    localparam int C_W       = SAMPLE_BITS + 1;
    localparam int H_W       = SAMPLE_BITS + 5;
    localparam int N_W       = SAMPLE_BITS + 29;
    localparam int RES_W     = N_W - FRAC_BITS - 1;
    localparam int PROD_A_W  = FRAC_BITS + 1 + A_W;
    localparam int PROD_H_W  = FRAC_BITS + 1 + H_W;

    localparam int PIPE_DEPTH = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATIO_W;
    localparam int CHAN_W     = 2;
    localparam int FRAMES_W   = 2;

    localparam logic [RATIO_W-1:0]  RATIO_MIN   = RATIO_W'(1) << (FRAC_BITS - 4);
    localparam logic [RATIO_W-1:0]  RATIO_MAX   = RATIO_W'(1) << (FRAC_BITS + 4);
    localparam logic [RATIO_W-1:0]  RATIO_RESET = RATIO_W'(1) << FRAC_BITS;
    localparam logic [POS_W:0]      POS_ONE     = (POS_W + 1)'(1) << FRAC_BITS;
    localparam logic [CHAN_W-1:0]   CHAN_MONO   = CHAN_W'(1);
    localparam logic [CHAN_W-1:0]   CHAN_STEREO = CHAN_W'(2);
    localparam logic [FRAMES_W-1:0] FRAMES_FULL = FRAMES_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_RATIO,
        REG_FOLD_TO_MONO,
        REG_OUTPUT_CHANNELS,
        REG_SOURCE_CHANNELS
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [3:0][SAMPLE_BITS-1:0]   window_t;
    typedef logic signed [N_W-1:0]         num_t;

    typedef struct packed {
        logic load;
        logic en;
    } lane_ctl_t;

    typedef struct packed {
        logic fold;
        logic copy;
    } mode_t;

    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

endpackage

### design/crsr_lane.sv
// One channel lane: Catmull-Rom coefficients and a six-stage Horner pipeline.
// Depends on crsr_pkg; instantiated twice by the top level.
module crsr_lane
    import crsr_pkg::*;
(
    input  logic                 clk,
    input  lane_ctl_t            ctl,
    input  window_t              window,
    input  logic [FRAC_BITS-1:0] t,
    output num_t                 num
);

    logic signed [B_W-1:0] w0, w1, w2, w3;
    logic signed [B_W-1:0] a_full, b_full, c_full;

    logic signed [A_W-1:0] a_reg;
    logic signed [B_W-1:0] b_reg;
    logic signed [C_W-1:0] c_reg;
    sample_t               p1_reg;

    logic [FRAC_BITS-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [PROD_A_W-1:0] prod1_reg, prod1_rnd;
    logic signed [H_W-1:0]      h1_reg, h1_sum;
    logic signed [PROD_H_W-1:0] prod2_reg, prod2_rnd;
    logic signed [H_W-1:0]      h2_reg, h2_sum;
    logic signed [PROD_H_W-1:0] prod3_reg;
    num_t                       num_reg, num_sum;

    assign w0 = B_W'($signed(window[0]));
    assign w1 = B_W'($signed(window[1]));
    assign w2 = B_W'($signed(window[2]));
    assign w3 = B_W'($signed(window[3]));

    assign a_full = w3 - w0 + (w1 - w2) + (w1 - w2) + (w1 - w2);
    assign b_full = w0 + w0 - (w1 <<< 2) - w1 + (w2 <<< 2) - w3;
    assign c_full = w2 - w0;

    // Each rounding adds one half LSB and keeps the upper bits (floor).
    assign prod1_rnd = prod1_reg + (PROD_A_W'(1) <<< (FRAC_BITS - 1));
    assign h1_sum    = H_W'(b_reg) + H_W'($signed(prod1_rnd[PROD_A_W-1:FRAC_BITS]));
    assign prod2_rnd = prod2_reg + (PROD_H_W'(1) <<< (FRAC_BITS - 1));
    assign h2_sum    = H_W'(c_reg) + H_W'($signed(prod2_rnd[PROD_H_W-1:FRAC_BITS]));
    assign num_sum   = (N_W'(p1_reg) <<< (FRAC_BITS + 1)) + N_W'(prod3_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg  <= $signed(a_full[A_W-1:0]);
            b_reg  <= b_full;
            c_reg  <= $signed(c_full[C_W-1:0]);
            p1_reg <= $signed(window[1]);
        end
        if (ctl.en)
        begin
            t1_reg    <= t;
            t2_reg    <= t1_reg;
            t3_reg    <= t2_reg;
            t4_reg    <= t3_reg;
            prod1_reg <= $signed({1'b0, t}) * a_reg;
            h1_reg    <= h1_sum;
            prod2_reg <= $signed({1'b0, t2_reg}) * h1_reg;
            h2_reg    <= h2_sum;
            prod3_reg <= $signed({1'b0, t4_reg}) * h2_reg;
            num_reg   <= num_sum;
        end
    end

    assign num = num_reg;

endmodule

### design/crsr_merge.sv
// Merging stage: rounds the lane numerators, folds to mono or copies, and saturates.
// Depends on crsr_pkg; fed by the two crsr_lane instances.
module crsr_merge
    import crsr_pkg::*;
(
    input  mode_t   mode,
    input  num_t    num_left,
    input  num_t    num_right,
    output sample_t left,
    output sample_t right
);

    logic signed [N_W:0]       fold_sum;
    logic signed [N_W-1:0]     left_rnd, right_rnd;
    logic signed [RES_W-1:0]   fold_val, left_val, right_val;
    sample_t                   left_sat, right_sat, fold_sat;

    function automatic sample_t saturate(input logic signed [RES_W-1:0] v);
        logic [RES_W-SAMPLE_BITS:0] top;
        sample_t                    res;
        top = v[RES_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            res = v[SAMPLE_BITS-1:0];
        else if (v[RES_W-1])
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return res;
    endfunction

    assign fold_sum  = (N_W + 1)'(num_left) + (N_W + 1)'(num_right)
                     + ((N_W + 1)'(1) <<< (FRAC_BITS + 1));
    assign left_rnd  = num_left + (N_W'(1) <<< FRAC_BITS);
    assign right_rnd = num_right + (N_W'(1) <<< FRAC_BITS);

    assign fold_val  = $signed(fold_sum[N_W:FRAC_BITS+2]);
    assign left_val  = $signed(left_rnd[N_W-1:FRAC_BITS+1]);
    assign right_val = $signed(right_rnd[N_W-1:FRAC_BITS+1]);

    assign fold_sat  = saturate(fold_val);
    assign left_sat  = saturate(left_val);
    assign right_sat = saturate(right_val);

    assign left  = mode.fold ? fold_sat : left_sat;
    assign right = mode.fold ? fold_sat : (mode.copy ? left_sat : right_sat);

endmodule

### design/catmull_rom_stereo_resampler.sv
// Top level of the Catmull-Rom stereo resampler: sequencer, window, position,
// two channel lanes, merging stage and output register.
// Depends on crsr_pkg, crsr_lane and crsr_merge.
//
//  Channel   Direction  Fields (lowest bit first)
//  s_axis    in         tuser: restart; tdata: left_in, right_in
//  m_axis    out        tdata: left_out, right_out; tlast: last
//  cfg       in         cfg_index selects register, cfg_data is written
//
// Once the window is full, an accepted item loads the lane coefficients,
// issues positions while m_axis does not stall and drains the lane pipelines
// before the next item is taken. The first two items after reset or restart
// only fill the window and yield no results. Reset clears window, position
// and valid flags and restores the settings; a stall on m_axis freezes the
// lanes, and a result may wait in the output register while a new item enters.
module catmull_rom_stereo_resampler
    import crsr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*SAMPLE_BITS-1:0] s_tdata,   // left_in, right_in
    input  logic [0:0]               s_tuser,   // restart
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*SAMPLE_BITS-1:0] m_tdata,   // left_out, right_out
    output logic                     m_tlast,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    state_t               state_reg, state_next;
    window_t              window_left_reg, window_left_next;
    window_t              window_right_reg, window_right_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [FRAMES_W-1:0]  frames_reg, frames_next;

    logic [RATIO_W-1:0]   ratio_reg;
    logic                 fold_reg;
    logic [CHAN_W-1:0]    out_ch_reg;
    logic [CHAN_W-1:0]    src_ch_reg;

    pipe_ctl_t [PIPE_DEPTH-1:0] pipe_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    sample_t              out_left_reg, out_right_reg;

    logic                 en;
    logic                 pipe_busy;
    logic                 accept;
    logic [RATIO_W-1:0]   ratio;
    logic [POS_W:0]       pos_sum;
    logic [FRAMES_W-1:0]  frames_base;
    pipe_ctl_t            issue;
    lane_ctl_t            lane_ctl;
    mode_t                mode;
    num_t                 num_left, num_right;
    sample_t              merged_left, merged_right;
    logic                 src_mono, out_mono;

    assign en     = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        if (ratio_reg < RATIO_MIN)
            ratio = RATIO_MIN;
        else if (ratio_reg > RATIO_MAX)
            ratio = RATIO_MAX;
        else
            ratio = ratio_reg;
    end

    assign src_mono  = (src_ch_reg == CHAN_MONO);
    assign out_mono  = (out_ch_reg == CHAN_MONO);
    assign mode      = '{fold: fold_reg && out_mono && !src_mono,
                         copy: src_mono || out_mono};

    assign pos_sum = (POS_W + 1)'(pos_reg) + (POS_W + 1)'(ratio);

    always_comb
    begin
        pipe_busy = 1'b0;
        for (int i = 0; i < PIPE_DEPTH; i++)
        begin
            pipe_busy = pipe_busy | pipe_reg[i].valid;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        window_left_next  = window_left_reg;
        window_right_next = window_right_reg;
        pos_next          = pos_reg;
        frames_next       = frames_reg;
        frames_base       = frames_reg;
        s_tready          = 1'b0;
        issue             = '0;
        lane_ctl.load     = 1'b0;
        lane_ctl.en       = en;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    // A restart clears the history before this frame enters.
                    if (s_tuser[0])
                    begin
                        window_left_next[2:0]  = '0;
                        window_right_next[2:0] = '0;
                        pos_next               = '0;
                        frames_base            = '0;
                    end
                    else
                    begin
                        window_left_next[2:0]  = window_left_reg[3:1];
                        window_right_next[2:0] = window_right_reg[3:1];
                    end
                    window_left_next[3]  = s_tdata[SAMPLE_BITS-1:0];
                    window_right_next[3] = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                    frames_next = (frames_base == FRAMES_FULL) ? frames_base
                                                               : frames_base + 1'b1;
                    if (frames_next == FRAMES_FULL)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                lane_ctl.load = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                if (pos_reg[POS_W-1:FRAC_BITS] != '0)
                begin
                    // No position falls in this window.
                    pos_next   = POS_W'((POS_W + 1)'(pos_reg) - POS_ONE);
                    state_next = ST_IDLE;
                end
                else if (en)
                begin
                    issue.valid = 1'b1;
                    issue.last  = (pos_sum >= POS_ONE);
                    if (issue.last)
                    begin
                        pos_next   = POS_W'(pos_sum - POS_ONE);
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_sum);
                    end
                end
            end
            ST_DRAIN:
            begin
                // The lane coefficients must stay until the last result leaves.
                if (!pipe_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_left_reg  <= '0;
            window_right_reg <= '0;
            pos_reg          <= '0;
            frames_reg       <= '0;
            ratio_reg        <= RATIO_RESET;
            fold_reg         <= 1'b0;
            out_ch_reg       <= CHAN_STEREO;
            src_ch_reg       <= CHAN_STEREO;
            pipe_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_left_reg  <= window_left_next;
            window_right_reg <= window_right_next;
            pos_reg          <= pos_next;
            frames_reg       <= frames_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RATE_RATIO:      ratio_reg  <= cfg_data[RATIO_W-1:0];
                    REG_FOLD_TO_MONO:    fold_reg   <= cfg_data[0];
                    REG_OUTPUT_CHANNELS: out_ch_reg <= cfg_data[CHAN_W-1:0];
                    REG_SOURCE_CHANNELS: src_ch_reg <= cfg_data[CHAN_W-1:0];
                    default:             ;
                endcase
            end
            if (en)
            begin
                pipe_reg      <= {pipe_reg[PIPE_DEPTH-2:0], issue};
                out_valid_reg <= pipe_reg[PIPE_DEPTH-1].valid;
                out_last_reg  <= pipe_reg[PIPE_DEPTH-1].last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_left_reg  <= merged_left;
            out_right_reg <= merged_right;
        end
    end

    crsr_lane u_lane_left (
        .clk    (clk),
        .ctl    (lane_ctl),
        .window (window_left_reg),
        .t      (pos_reg[FRAC_BITS-1:0]),
        .num    (num_left)
    );

    crsr_lane u_lane_right (
        .clk    (clk),
        .ctl    (lane_ctl),
        .window (window_right_reg),
        .t      (pos_reg[FRAC_BITS-1:0]),
        .num    (num_right)
    );

    crsr_merge u_merge (
        .mode      (mode),
        .num_left  (num_left),
        .num_right (num_right),
        .left      (merged_left),
        .right     (merged_right)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};

endmodule

### design/crsr_checker.sv
// Port-level checks of the Catmull-Rom stereo resampler, bound to the top level.
// Depends only on the top level's ports.
module crsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // A restart frame is only the first of the warm-up, so input stays open.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> s_tready)
        else $error("input closed after a restart item");

    // No result can come out in the cycle right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early after an item");

    // The results of one item come without gaps until the one marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the results of one item");

endmodule

bind catmull_rom_stereo_resampler crsr_checker u_crsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/sv/crsr_checker.sv
`timescale 1ns / 100ps
// Checker for the Catmull-Rom stereo resampler: follows register writes and
// accepted source items, predicts every output item and compares field by field.
// Depends on crsr_pkg only.
module crsr_tb_checker
    import crsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,   // left_in, right_in
    input  logic [0:0]            s_tuser,   // restart
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [47:0]           m_tdata,   // left_out, right_out
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    fail_count
);

    localparam int          MAX_PER_FRAME = 16;
    localparam longint      Q24           = longint'(1) << FRAC_BITS;
    localparam longint      SAMPLE_HI     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint      SAMPLE_LO     = -SAMPLE_HI - 1;
    localparam logic [31:0] POS_UNIT      = 32'd1 << FRAC_BITS;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    last;
    } out_frame_t;

    out_frame_t expected_q[$];

    logic [RATIO_W-1:0] ratio_reg;
    logic               fold_reg;
    logic [CHAN_W-1:0]  out_chan_reg;
    logic [CHAN_W-1:0]  src_chan_reg;
    longint             hist_l[4];
    longint             hist_r[4];
    logic [31:0]        position;
    int                 frames_in;

    function automatic longint rounded_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Twice the interpolated value, scaled by 2^24; p0 is the oldest frame.
    function automatic longint spline_num(longint p0, longint p1, longint p2,
                                          longint p3, longint frac);
        longint a, b, c, h1, h2;
        a  = -p0 + 3 * p1 - 3 * p2 + p3;
        b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c  = p2 - p0;
        h1 = rounded_shift(b * Q24 + frac * a, FRAC_BITS);
        h2 = rounded_shift(c * Q24 + frac * h1, FRAC_BITS);
        return 2 * p1 * Q24 + frac * h2;
    endfunction

    function automatic sample_t clip_sample(longint v);
        if (v > SAMPLE_HI)
            return sample_t'(SAMPLE_HI);
        if (v < SAMPLE_LO)
            return sample_t'(SAMPLE_LO);
        return sample_t'(v);
    endfunction

    function automatic void clear_stream();
        for (int i = 0; i < 4; i++)
        begin
            hist_l[i] = 0;
            hist_r[i] = 0;
        end
        position  = '0;
        frames_in = 0;
    endfunction

    function automatic void resample_frame(logic restart, sample_t left_in, sample_t right_in);
        logic        src_mono, out_mono, fold;
        logic [31:0] stride;
        longint      frac, nl, nr;
        out_frame_t  item;
        int          n;
        src_mono = (src_chan_reg == CHAN_MONO);
        out_mono = (out_chan_reg == CHAN_MONO);
        fold     = fold_reg && out_mono && !src_mono;
        if (ratio_reg < RATIO_MIN)
            stride = 32'(RATIO_MIN);
        else if (ratio_reg > RATIO_MAX)
            stride = 32'(RATIO_MAX);
        else
            stride = 32'(ratio_reg);

        if (restart)
            clear_stream();
        for (int i = 0; i < 3; i++)
        begin
            hist_l[i] = hist_l[i + 1];
            hist_r[i] = hist_r[i + 1];
        end
        hist_l[3] = longint'(left_in);
        hist_r[3] = longint'(right_in);
        if (frames_in < 3)
            frames_in++;
        if (frames_in < 3)
            return;

        n = 0;
        while (position < POS_UNIT && n < MAX_PER_FRAME)
        begin
            frac = longint'(position);
            nl   = spline_num(hist_l[0], hist_l[1], hist_l[2], hist_l[3], frac);
            nr   = spline_num(hist_r[0], hist_r[1], hist_r[2], hist_r[3], frac);
            if (fold)
            begin
                item.left  = clip_sample(rounded_shift(nl + nr, FRAC_BITS + 2));
                item.right = item.left;
            end
            else
            begin
                item.left  = clip_sample(rounded_shift(nl, FRAC_BITS + 1));
                item.right = (src_mono || out_mono)
                           ? item.left
                           : clip_sample(rounded_shift(nr, FRAC_BITS + 1));
            end
            position += stride;
            n++;
            // The last item of a frame has no position after it, or is the sixteenth.
            item.last = (position >= POS_UNIT) || (n == MAX_PER_FRAME);
            expected_q.insert(expected_q.size(), item);
        end
        while (position < POS_UNIT)
            position += stride;
        position -= POS_UNIT;
    endfunction

    task automatic report(string field, longint want, longint got);
        $display("%0t ERROR %s: expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_frame_t want;
        if (!rst_n)
        begin
            ratio_reg    = RATIO_RESET;
            fold_reg     = 1'b0;
            out_chan_reg = CHAN_STEREO;
            src_chan_reg = CHAN_STEREO;
            clear_stream();
            expected_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE_RATIO:      ratio_reg    = cfg_data[RATIO_W-1:0];
                    REG_FOLD_TO_MONO:    fold_reg     = cfg_data[0];
                    REG_OUTPUT_CHANNELS: out_chan_reg = cfg_data[CHAN_W-1:0];
                    REG_SOURCE_CHANNELS: src_chan_reg = cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display({"%0t ERROR unexpected item: expected none, ",
                              "actual left %0d right %0d last %0b"},
                             $time, $signed(m_tdata[SAMPLE_BITS-1:0]),
                             $signed(m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]), m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want.left)
                        report("left_out", want.left, $signed(m_tdata[SAMPLE_BITS-1:0]));
                    if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right)
                        report("right_out", want.right,
                               $signed(m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                    if (m_tlast !== want.last)
                        report("last", want.last, m_tlast);
                end
            end

            if (s_tvalid && s_tready)
                resample_frame(s_tuser[0], s_tdata[SAMPLE_BITS-1:0],
                               s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

            pending <= expected_q.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top of the Catmull-Rom stereo resampler: clock, reset, register
// writes, source items and sink stalls. Depends on crsr_pkg, crsr_checker and the RTL.
module tb_top
    import crsr_pkg::*;
();

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 30;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 20;

    localparam sample_t           S_MAX       = 24'sh7FFFFF;
    localparam sample_t           S_MIN       = 24'sh800000;
    localparam logic [CHAN_W-1:0] CHAN_ZERO   = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_THREE  = 2'd3;
    localparam logic [RATIO_W-1:0] RATIO_TOP  = '1;
    localparam logic [RATIO_W-1:0] RATIO_1P5  = RATIO_RESET + (RATIO_RESET >> 1);

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int fail_count;
    int cycles = 0;
    int sink_mode = 0;
    int sink_hold;

    catmull_rom_stereo_resampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crsr_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Back-pressure: none in mode 0, else mostly short stalls, now and then a long one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else if (sink_hold > 0)
            sink_hold <= sink_hold - 1;
        else if (sink_mode == 0)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
        end
        else
        begin
            m_tready  <= 1'b1;
            sink_hold <= $urandom_range(0, 4);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits of the narrow registers carry junk that the block must drop.
    task automatic load_settings(logic [RATIO_W-1:0] ratio, logic fold,
                                 logic [CHAN_W-1:0] out_ch, logic [CHAN_W-1:0] src_ch);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_RATE_RATIO, ratio);
        write_reg(REG_FOLD_TO_MONO, {junk[CFG_DATA_W-1:1], fold});
        write_reg(REG_OUTPUT_CHANNELS, {junk[CFG_DATA_W-1:CHAN_W], out_ch});
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SOURCE_CHANNELS, {junk[CFG_DATA_W-1:CHAN_W], src_ch});
    endtask

    // Valid stays high into the next item when no gap follows.
    task automatic send_frame(logic restart, sample_t left, sample_t right, int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= {right, left};
        do
            @(posedge clk);
        while (!s_tready);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_gap(int mode);
        if (mode == 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    function automatic sample_t pick_sample(int shift);
        sample_t v;
        v = sample_t'($urandom);
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            default: return v >>> shift;
        endcase
    endfunction

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 7))
            0:       return RATIO_W'($urandom_range(0, RATIO_MIN));
            1:       return RATIO_W'($urandom_range(RATIO_MAX, RATIO_TOP));
            2:       return RATIO_RESET;
            3:       return RATIO_W'($urandom_range(RATIO_MIN, RATIO_RESET));
            default: return RATIO_W'($urandom_range(RATIO_MIN, 4 * RATIO_RESET));
        endcase
    endfunction

    initial
    begin
        logic               restart;
        int                 shift;
        int                 src_mode;
        logic [RATIO_W-1:0] ratio;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RATE_RATIO;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ratio 1.0 in stereo passes the input two items late.
        send_frame(1'b1, S_MAX, S_MIN, 0);
        send_frame(1'b0, S_MIN, S_MAX, 0);
        send_frame(1'b0, S_MAX, S_MAX, 0);
        send_frame(1'b0, S_MIN, S_MIN, 0);
        send_frame(1'b0, 24'sd0, 24'sd0, 0);
        send_frame(1'b0, 24'sd1, -24'sd1, 0);
        send_frame(1'b1, 24'sd123456, -24'sd654321, 0);
        send_frame(1'b0, S_MAX, S_MIN, 0);
        send_frame(1'b0, -24'sd2, 24'sd7, 0);
        drain_and_settle();

        // Ratio below the floor with folding active: sixteen items per frame.
        load_settings('0, 1'b1, CHAN_MONO, CHAN_STEREO);
        send_frame(1'b1, S_MAX, S_MAX, 0);
        send_frame(1'b0, S_MIN, S_MIN, 0);
        send_frame(1'b0, S_MAX, S_MIN, 0);
        send_frame(1'b0, S_MIN, S_MAX, 0);
        send_frame(1'b0, S_MAX, S_MAX, 0);
        drain_and_settle();

        // Ratio above the ceiling with a mono source copied to both outputs.
        load_settings(RATIO_TOP, 1'b0, CHAN_STEREO, CHAN_MONO);
        send_frame(1'b1, S_MIN, S_MAX, 0);
        send_frame(1'b0, S_MAX, 24'sd0, 0);
        send_frame(1'b0, S_MIN, 24'sd5, 0);
        send_frame(1'b0, 24'sd100, S_MIN, 0);
        send_frame(1'b0, S_MAX, S_MAX, 0);
        send_frame(1'b0, 24'sd0, 24'sd0, 0);
        drain_and_settle();

        // Odd channel codes count as stereo, so the fold request is ignored.
        load_settings(RATIO_1P5, 1'b1, CHAN_ZERO, CHAN_THREE);
        send_frame(1'b1, S_MAX, S_MIN, 0);
        send_frame(1'b0, S_MIN, S_MAX, 0);
        send_frame(1'b0, 24'sd4096, -24'sd4096, 0);
        send_frame(1'b0, S_MAX, S_MAX, 0);
        send_frame(1'b0, S_MIN, S_MIN, 0);
        drain_and_settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            ratio = (ph == 0) ? RATIO_MIN : (ph == 1) ? RATIO_MAX : pick_ratio();
            load_settings(ratio, 1'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, 3)),
                          CHAN_W'($urandom_range(0, 3)));
            sink_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            src_mode  = ($urandom_range(0, 3) == 0) ? 0 : 1;
            shift     = $urandom_range(0, 12);
            for (int k = 0; k < FRAMES_PER_PHASE; k++)
            begin
                restart = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
                send_frame(restart, pick_sample(shift), pick_sample(shift), pick_gap(src_mode));
            end
            drain_and_settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
